/* design/pfi_pkg.sv */
// pfi_pkg: shared constants, operation codes and saturation helpers
// for the particle force and integrate core. no dependencies.
`timescale 1ns / 1ps

package pfi_pkg;

	localparam int PFI_PARTICLES = 1024;

	localparam logic [15:0] DAMP_RESET = 16'd4588;
	localparam logic [16:0] Q_ONE = 17'h10000;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 17;

	localparam logic [2:0] OP_LOAD = 3'd0;
	localparam logic [2:0] OP_ADD = 3'd1;
	localparam logic [2:0] OP_POINT = 3'd2;
	localparam logic [2:0] OP_PAIR = 3'd3;
	localparam logic [2:0] OP_INTEG = 3'd4;

	localparam logic [1:0] MODE_REPEL = 2'd0;
	localparam logic [1:0] MODE_ATTRACT = 2'd1;
	localparam logic [1:0] MODE_CW = 2'd2;
	localparam logic [1:0] MODE_CCW = 2'd3;

	typedef logic [31:0] q16_t;

	function automatic logic [33:0] ext34(input logic [31:0] v);
		return {{2{v[31]}}, v};
	endfunction

	function automatic logic [33:0] ext34w(input logic [32:0] v);
		return {v[32], v};
	endfunction

	function automatic q16_t sat32(input logic [33:0] v);
		q16_t r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = 32'h8000_0000;
		end else begin
			r = 32'h7fff_ffff;
		end
		return r;
	endfunction

endpackage

/* design/pfi_sqrt.sv */
// pfi_sqrt: iterative integer square root, two radicand bits per cycle
// depends on pfi_pkg
`timescale 1ns / 1ps

module pfi_sqrt import pfi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] rad,
	output logic        done,
	output logic [31:0] root
);

	localparam int CW = $clog2(SQRT_STEPS);

	logic [63:0]   rad_q;
	logic [34:0]   rem_q;
	logic [31:0]   root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [34:0]   rem_n, trial;

	assign rem_n = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SQRT_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[61:0], 2'b00};
			if (rem_n >= trial) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* design/pfi_div.sv */
// pfi_div: restoring divider, one quotient bit per cycle, 17-bit quotient
// depends on pfi_pkg
`timescale 1ns / 1ps

module pfi_div import pfi_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] num,
	input  logic [31:0] den,
	output logic        done,
	output logic [16:0] quo
);

	localparam int CW = $clog2(DIV_STEPS);

	logic [31:0]   r_q, den_q;
	logic [16:0]   n_q, q_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	logic [32:0]   r2;

	assign r2 = {r_q, n_q[16]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= {1'b0, num[47:17]};
			n_q   <= num[16:0];
			q_q   <= '0;
			den_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[15:0], 1'b0};
			if (r2 >= {1'b0, den_q}) begin
				r_q <= 32'(r2 - {1'b0, den_q});
				q_q <= {q_q[15:0], 1'b1};
			end else begin
				r_q <= r2[31:0];
				q_q <= {q_q[15:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = q_q;

endmodule

/* design/particle_force_and_integrate_core.sv */
// particle_force_and_integrate_core: particle tables and operation sequencer
// depends on pfi_pkg, pfi_sqrt, pfi_div
`timescale 1ns / 1ps

// Holds PARTICLES 2D particles (position, velocity, acceleration, Q16.16) in three
// single-port synchronous memories and runs one operation at a time. After reset a
// clearing pass writes zero to every entry, with in_ready low. Pair forces, and
// point forces in repel and attract modes, run the 32-step square root and up
// to three 17-step divisions of the shared iterative units. The result sits in
// an output register, so the next word is taken while the previous result waits.

module particle_force_and_integrate_core import pfi_pkg::*; #(
	parameter int PARTICLES = PFI_PARTICLES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         operation,
	input  logic [1:0]         force_mode,
	input  logic [9:0]         first_index,
	input  logic [9:0]         second_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] load_vel_x,
	input  logic signed [31:0] load_vel_y,
	input  logic [30:0]        reach,
	input  logic signed [31:0] strength,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               status,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] vel_x,
	output logic signed [31:0] vel_y,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data
);

	localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	localparam logic [4:0] ST_CLEAR = 5'd0;
	localparam logic [4:0] ST_IDLE  = 5'd1;
	localparam logic [4:0] ST_RDA   = 5'd2;
	localparam logic [4:0] ST_DEC   = 5'd3;
	localparam logic [4:0] ST_DIFF  = 5'd4;
	localparam logic [4:0] ST_SQA   = 5'd5;
	localparam logic [4:0] ST_SQB   = 5'd6;
	localparam logic [4:0] ST_SQR   = 5'd7;
	localparam logic [4:0] ST_CMP   = 5'd8;
	localparam logic [4:0] ST_SQRT  = 5'd9;
	localparam logic [4:0] ST_DPCT  = 5'd10;
	localparam logic [4:0] ST_DUX   = 5'd11;
	localparam logic [4:0] ST_DUY   = 5'd12;
	localparam logic [4:0] ST_F1    = 5'd13;
	localparam logic [4:0] ST_F2    = 5'd14;
	localparam logic [4:0] ST_F3    = 5'd15;
	localparam logic [4:0] ST_F4    = 5'd16;
	localparam logic [4:0] ST_F5    = 5'd17;
	localparam logic [4:0] ST_AWR   = 5'd18;
	localparam logic [4:0] ST_BRD   = 5'd19;
	localparam logic [4:0] ST_BWR   = 5'd20;
	localparam logic [4:0] ST_I1    = 5'd21;
	localparam logic [4:0] ST_I2    = 5'd22;
	localparam logic [4:0] ST_I3    = 5'd23;
	localparam logic [4:0] ST_I4    = 5'd24;
	localparam logic [4:0] ST_ORD   = 5'd25;
	localparam logic [4:0] ST_OUT   = 5'd26;

	logic [4:0]    state_q, state_n;
	logic [AW-1:0] clr_q, ia_q, ib_q;
	logic          a_ok_q, b_ok_q;
	logic [2:0]    op_q;
	logic [1:0]    mode_q;
	q16_t          px_q, py_q, vx_q, vy_q, str_q;
	logic [30:0]   reach_q;
	logic [15:0]   damping_q;
	logic          st_q;
	q16_t          pax_q, pay_q;
	logic [30:0]   ax_q, ay_q;
	logic          sx_q, sy_q;
	logic [63:0]   s_q, mul_q;
	logic [31:0]   mul_a, mul_b;
	logic [31:0]   len_q;
	logic [16:0]   pct_q, ux_q, uy_q;
	q16_t          t1x_q, t1y_q, fmx_q, fmy_q;
	q16_t          vsx_q, vsy_q;
	logic [32:0]   wx_q, wy_q;

	logic          out_valid_q, out_st_q;
	q16_t          out_px_q, out_py_q, out_vx_q, out_vy_q;

	logic [63:0]   pos_mem [PARTICLES];
	logic [63:0]   vel_mem [PARTICLES];
	logic [63:0]   acc_mem [PARTICLES];
	logic [63:0]   pos_rd, vel_rd, acc_rd;
	logic          rd_en, pos_we, vel_we, acc_we;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0]   pos_wd, vel_wd, acc_wd;

	logic          sq_start, sq_done, dv_start, dv_done;
	logic [31:0]   sq_root, dv_den;
	logic [47:0]   dv_num;
	logic [16:0]   dv_quo;

	logic [31:0]   fi_w, si_w;
	logic          accept;
	q16_t          src_x, src_y, smag, vmag;
	logic [32:0]   dx, dy, adx, ady, fx, fy, fa_x, fa_y, fs_x, fs_y;
	logic [30:0]   pct_diff;
	logic [16:0]   kmul;
	q16_t          vs_x, vs_y;

	assign fi_w     = 32'(first_index);
	assign si_w     = 32'(second_index);
	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign kmul     = Q_ONE - {1'b0, damping_q};

	// datapath helpers
	assign src_x = (op_q == OP_PAIR) ? pos_rd[31:0] : px_q;
	assign src_y = (op_q == OP_PAIR) ? pos_rd[63:32] : py_q;
	assign dx    = {pax_q[31], pax_q} - {src_x[31], src_x};
	assign dy    = {pay_q[31], pay_q} - {src_y[31], src_y};
	assign adx   = dx[32] ? (33'd0 - dx) : dx;
	assign ady   = dy[32] ? (33'd0 - dy) : dy;
	assign smag  = str_q[31] ? (32'd0 - str_q) : str_q;
	assign vmag  = (state_q == ST_I1) ? (vsx_q[31] ? 32'd0 - vsx_q : vsx_q)
	                                 : (vsy_q[31] ? 32'd0 - vsy_q : vsy_q);
	assign fx    = (sx_q ^ str_q[31]) ? (33'd0 - {1'b0, fmx_q}) : {1'b0, fmx_q};
	assign fy    = (sy_q ^ str_q[31]) ? (33'd0 - {1'b0, fmy_q}) : {1'b0, fmy_q};
	assign pct_diff = reach_q - sq_root[30:0];
	assign vs_x  = sat32(ext34(vel_rd[31:0]) + ext34(acc_rd[31:0]));
	assign vs_y  = sat32(ext34(vel_rd[63:32]) + ext34(acc_rd[63:32]));

	always_comb begin
		unique case (mode_q)
			MODE_REPEL: begin
				fa_x = fx;
				fa_y = fy;
			end
			MODE_ATTRACT: begin
				fa_x = 33'd0 - fx;
				fa_y = 33'd0 - fy;
			end
			MODE_CW: begin
				fa_x = 33'd0 - fy;
				fa_y = fx;
			end
			MODE_CCW: begin
				fa_x = fy;
				fa_y = 33'd0 - fx;
			end
			default: begin
				fa_x = fx;
				fa_y = fy;
			end
		endcase
	end

	// partner gets the opposite force
	assign fs_x = (state_q == ST_BWR) ? (33'd0 - fa_x) : fa_x;
	assign fs_y = (state_q == ST_BWR) ? (33'd0 - fa_y) : fa_y;

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_SQA: begin
				mul_a = {1'b0, ax_q};
				mul_b = {1'b0, ax_q};
			end
			ST_SQB: begin
				mul_a = {1'b0, ay_q};
				mul_b = {1'b0, ay_q};
			end
			ST_SQR: begin
				mul_a = {1'b0, reach_q};
				mul_b = {1'b0, reach_q};
			end
			ST_F1: begin
				mul_a = 32'(ux_q);
				mul_b = smag;
			end
			ST_F2: begin
				mul_a = 32'(uy_q);
				mul_b = smag;
			end
			ST_F3: begin
				mul_a = t1x_q;
				mul_b = 32'(pct_q);
			end
			ST_F4: begin
				mul_a = t1y_q;
				mul_b = 32'(pct_q);
			end
			ST_I1, ST_I2: begin
				mul_a = vmag;
				mul_b = 32'(kmul);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= 64'(mul_a) * 64'(mul_b);
	end

	// divider and square root control
	assign sq_start = (state_q == ST_CMP) && !(s_q > mul_q);
	assign dv_start = ((state_q == ST_SQRT) && sq_done) ||
	                  ((state_q == ST_DPCT) && dv_done && (len_q != '0)) ||
	                  ((state_q == ST_DUX) && dv_done);

	always_comb begin
		unique case (state_q)
			ST_SQRT: begin
				dv_num = {1'b0, pct_diff, 16'h0000};
				dv_den = {1'b0, reach_q};
			end
			ST_DPCT: begin
				dv_num = {1'b0, ax_q, 16'h0000};
				dv_den = len_q;
			end
			default: begin
				dv_num = {1'b0, ay_q, 16'h0000};
				dv_den = len_q;
			end
		endcase
	end

	pfi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (s_q),
		.done   (sq_done),
		.root   (sq_root)
	);

	pfi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quo    (dv_quo)
	);

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ia_q;
		wr_addr = ia_q;
		pos_we  = 1'b0;
		vel_we  = 1'b0;
		acc_we  = 1'b0;
		pos_wd  = {py_q, px_q};
		vel_wd  = {vy_q, vx_q};
		acc_wd  = {sat32(ext34(acc_rd[63:32]) + ext34w(fs_y)),
		           sat32(ext34(acc_rd[31:0]) + ext34w(fs_x))};
		unique case (state_q)
			ST_CLEAR: begin
				wr_addr = clr_q;
				pos_we  = 1'b1;
				vel_we  = 1'b1;
				acc_we  = 1'b1;
				pos_wd  = '0;
				vel_wd  = '0;
				acc_wd  = '0;
			end
			ST_RDA, ST_F5, ST_ORD: begin
				rd_en = 1'b1;
			end
			ST_DEC: begin
				if (a_ok_q && op_q == OP_LOAD) begin
					pos_we = 1'b1;
					vel_we = 1'b1;
				end
				if (a_ok_q && op_q == OP_ADD) begin
					acc_we = 1'b1;
					acc_wd = {sat32(ext34(acc_rd[63:32]) + ext34(py_q)),
					          sat32(ext34(acc_rd[31:0]) + ext34(px_q))};
				end
				if (a_ok_q && op_q == OP_PAIR && b_ok_q) begin
					rd_en   = 1'b1;
					rd_addr = ib_q;
				end
			end
			ST_AWR: begin
				acc_we = 1'b1;
			end
			ST_BRD: begin
				rd_en   = 1'b1;
				rd_addr = ib_q;
			end
			ST_BWR: begin
				acc_we  = 1'b1;
				wr_addr = ib_q;
			end
			ST_I4: begin
				pos_we = 1'b1;
				vel_we = 1'b1;
				acc_we = 1'b1;
				vel_wd = {sat32(ext34w(wy_q)), sat32(ext34w(wx_q))};
				pos_wd = {sat32(ext34(pay_q) + ext34w(wy_q)),
				          sat32(ext34(pax_q) + ext34w(wx_q))};
				acc_wd = '0;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[wr_addr] <= pos_wd;
		end
		if (rd_en) begin
			pos_rd <= pos_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (vel_we) begin
			vel_mem[wr_addr] <= vel_wd;
		end
		if (rd_en) begin
			vel_rd <= vel_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (acc_we) begin
			acc_mem[wr_addr] <= acc_wd;
		end
		if (rd_en) begin
			acc_rd <= acc_mem[rd_addr];
		end
	end

	// sequencer
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == AW'(PARTICLES - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_n = ST_RDA;
				end
			end
			ST_RDA: state_n = ST_DEC;
			ST_DEC: begin
				state_n = ST_ORD;
				if (a_ok_q) begin
					priority if (op_q == OP_POINT && !mode_q[1]) begin
						state_n = ST_DIFF;
					end else if (op_q == OP_PAIR && b_ok_q) begin
						state_n = ST_DIFF;
					end else if (op_q == OP_INTEG) begin
						state_n = ST_I1;
					end else begin
						state_n = ST_ORD;
					end
				end
			end
			ST_DIFF: begin
				if (reach_q == '0 || adx[32] || adx[31] || ady[32] || ady[31]) begin
					state_n = ST_ORD;
				end else begin
					state_n = ST_SQA;
				end
			end
			ST_SQA: state_n = ST_SQB;
			ST_SQB: state_n = ST_SQR;
			ST_SQR: state_n = ST_CMP;
			ST_CMP: state_n = (s_q > mul_q) ? ST_ORD : ST_SQRT;
			ST_SQRT: begin
				if (sq_done) begin
					state_n = ST_DPCT;
				end
			end
			ST_DPCT: begin
				if (dv_done) begin
					state_n = (len_q == '0) ? ST_F1 : ST_DUX;
				end
			end
			ST_DUX: begin
				if (dv_done) begin
					state_n = ST_DUY;
				end
			end
			ST_DUY: begin
				if (dv_done) begin
					state_n = ST_F1;
				end
			end
			ST_F1: state_n = ST_F2;
			ST_F2: state_n = ST_F3;
			ST_F3: state_n = ST_F4;
			ST_F4: state_n = ST_F5;
			ST_F5: state_n = ST_AWR;
			ST_AWR: state_n = (op_q == OP_PAIR) ? ST_BRD : ST_ORD;
			ST_BRD: state_n = ST_BWR;
			ST_BWR: state_n = ST_ORD;
			ST_I1: state_n = ST_I2;
			ST_I2: state_n = ST_I3;
			ST_I3: state_n = ST_I4;
			ST_I4: state_n = ST_ORD;
			ST_ORD: state_n = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			damping_q   <= DAMP_RESET;
			out_valid_q <= 1'b0;
			st_q        <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_wr_en) begin
				damping_q <= cfg_wr_data;
			end
			if (accept) begin
				st_q <= 1'b0;
			end else if (state_q == ST_DIFF && state_n == ST_ORD) begin
				st_q <= 1'b1;
			end else if (state_q == ST_CMP && state_n == ST_ORD) begin
				st_q <= 1'b1;
			end
			if (state_q == ST_OUT && state_n == ST_IDLE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			mode_q  <= force_mode;
			ia_q    <= fi_w[AW-1:0];
			ib_q    <= si_w[AW-1:0];
			a_ok_q  <= (fi_w < 32'(PARTICLES));
			b_ok_q  <= (si_w < 32'(PARTICLES));
			px_q    <= point_x;
			py_q    <= point_y;
			vx_q    <= load_vel_x;
			vy_q    <= load_vel_y;
			reach_q <= reach;
			str_q   <= strength;
		end
		if (state_q == ST_DEC) begin
			pax_q <= pos_rd[31:0];
			pay_q <= pos_rd[63:32];
			vsx_q <= vs_x;
			vsy_q <= vs_y;
		end
		if (state_q == ST_DIFF) begin
			ax_q <= adx[30:0];
			ay_q <= ady[30:0];
			sx_q <= dx[32];
			sy_q <= dy[32];
		end
		if (state_q == ST_SQB) begin
			s_q <= mul_q;
		end
		if (state_q == ST_SQR) begin
			s_q <= s_q + mul_q;
		end
		if (state_q == ST_SQRT && sq_done) begin
			len_q <= sq_root;
		end
		if (state_q == ST_DPCT && dv_done) begin
			pct_q <= dv_quo;
			ux_q  <= '0;
			uy_q  <= '0;
		end
		if (state_q == ST_DUX && dv_done) begin
			ux_q <= dv_quo;
		end
		if (state_q == ST_DUY && dv_done) begin
			uy_q <= dv_quo;
		end
		if (state_q == ST_F2) begin
			t1x_q <= mul_q[47:16];
		end
		if (state_q == ST_F3) begin
			t1y_q <= mul_q[47:16];
		end
		if (state_q == ST_F4) begin
			fmx_q <= mul_q[47:16];
		end
		if (state_q == ST_F5) begin
			fmy_q <= mul_q[47:16];
		end
		if (state_q == ST_I2) begin
			wx_q <= vsx_q[31] ? (33'd0 - {1'b0, mul_q[47:16]}) : {1'b0, mul_q[47:16]};
		end
		if (state_q == ST_I3) begin
			wy_q <= vsy_q[31] ? (33'd0 - {1'b0, mul_q[47:16]}) : {1'b0, mul_q[47:16]};
		end
		if (state_q == ST_OUT && state_n == ST_IDLE) begin
			out_st_q <= st_q;
			out_px_q <= a_ok_q ? pos_rd[31:0] : '0;
			out_py_q <= a_ok_q ? pos_rd[63:32] : '0;
			out_vx_q <= a_ok_q ? vel_rd[31:0] : '0;
			out_vy_q <= a_ok_q ? vel_rd[63:32] : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_st_q;
	assign pos_x     = out_px_q;
	assign pos_y     = out_py_q;
	assign vel_x     = out_vx_q;
	assign vel_y     = out_vy_q;

endmodule

/* design/pfi_chk.sv */
// pfi_chk: port-level checks for particle_force_and_integrate_core, with bind
// depends on particle_force_and_integrate_core
`timescale 1ns / 1ps

module pfi_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               status,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] vel_x,
	input logic signed [31:0] vel_y
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(vel_x) && $stable(vel_y) && $stable(status))
		else $error("result word changed while stalled");

	// one word in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a new result only appears while a word is being worked on
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result without work");

endmodule

bind particle_force_and_integrate_core pfi_chk u_pfi_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.pos_x     (pos_x),
	.pos_y     (pos_y),
	.vel_x     (vel_x),
	.vel_y     (vel_y)
);
